>>> rtl/gate_controller_with_alarm_blink_core_assert.svh
// Assertion macros for the gate controller checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef GATE_CONTROLLER_WITH_ALARM_BLINK_CORE_ASSERT_SVH
`define GATE_CONTROLLER_WITH_ALARM_BLINK_CORE_ASSERT_SVH

// same-cycle implication
`define GCAB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gcab assertion failed");

// next-cycle implication
`define GCAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gcab assertion failed");

`endif

>>> rtl/gcab_pkg.sv
// Shared types, constants and helper functions of the gate controller.
// No dependencies; imported by every module of the block.
package gcab_pkg;

  localparam int unsigned TIMER_BITS = 10;
  localparam int unsigned TIMER_MAX  = (1 << TIMER_BITS) - 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef logic [TIMER_BITS-1:0] timer_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TICKS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_HALF_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_PULSE_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_SHORT_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LONG_GAP    = 3'd4;

  // register reset values
  localparam logic [9:0] RST_TRAVEL_TICKS      = 10'd40;
  localparam logic [7:0] RST_LAMP_HALF_PERIOD  = 8'd3;
  localparam logic [7:0] RST_ALARM_PULSE_TICKS = 8'd2;
  localparam logic [7:0] RST_ALARM_SHORT_GAP   = 8'd4;
  localparam logic [7:0] RST_ALARM_LONG_GAP    = 8'd20;

  // lamp reload when a closing gate is reversed
  localparam logic [7:0] LAMP_REVERSE_LOAD = 8'd5;

  // alarm codes
  localparam logic [2:0] ALM_NONE       = 3'd0;
  localparam logic [2:0] ALM_OBSTACLE   = 3'd1;
  localparam logic [2:0] ALM_INCOMPLETE = 3'd2;
  localparam logic [2:0] ALM_TIMEOUT    = 3'd3;
  localparam logic [2:0] ALM_SENSOR     = 3'd5;

  // gate state numbers as seen on the result
  localparam logic [2:0] GS_INIT      = 3'd0;
  localparam logic [2:0] GS_CLOSED    = 3'd1;
  localparam logic [2:0] GS_OPENING   = 3'd2;
  localparam logic [2:0] GS_OPEN      = 3'd3;
  localparam logic [2:0] GS_CLOSING   = 3'd4;
  localparam logic [2:0] GS_OP_PAUSE  = 3'd5;
  localparam logic [2:0] GS_CL_PAUSE  = 3'd6;
  localparam logic [2:0] GS_RECOVERY  = 3'd7;

  typedef struct packed {
    logic open_button;
    logic close_button;
    logic fully_open;
    logic fully_closed;
    logic photocell;
  } in_t;

  typedef struct packed {
    logic       motor_on;
    logic       direction_open;
    logic       warning_lamp;
    logic       entry_green;
    logic       led_closed;
    logic       led_open;
    logic       led_three;
    logic       led_four;
    logic       led_motion;
    logic       led_alarm;
    logic [2:0] gate_state;
    logic [2:0] alarm_code;
  } out_t;

  typedef struct packed {
    logic [9:0] travel_ticks;
    logic [7:0] lamp_half_period;
    logic [7:0] alarm_pulse_ticks;
    logic [7:0] alarm_short_gap;
    logic [7:0] alarm_long_gap;
  } cfg_t;

  // output latches held by the gate machine
  typedef struct packed {
    logic motor;
    logic dir;
    logic lamp;
    logic entry;
    logic l_closed;
    logic l_open;
    logic l_three;
    logic l_four;
    logic l_motion;
  } lat_t;

  typedef struct packed {
    lat_t       lat;
    logic [2:0] gate_state;
    logic [2:0] pend;
  } gate_out_t;

  typedef struct packed {
    logic       led_alarm;
    logic [2:0] alarm_code;
  } alarm_out_t;

  function automatic timer_t travel_load(input logic [9:0] v);
    if (32'(v) > TIMER_MAX) begin
      return timer_t'(TIMER_MAX);
    end
    return timer_t'(v);
  endfunction

  // t/10 + 1; reciprocal multiply, exact for any 10-bit operand
  function automatic timer_t blink_reload(input timer_t t);
    logic [31:0] p;
    p = 32'(t) * 32'd52429;
    return timer_t'((p >> 19) + 32'd1);
  endfunction

endpackage

>>> rtl/gcab_gate.sv
// Gate state machine with travel, blink and lamp timers and output latches.
// Depends on gcab_pkg; pending alarm register lives in gcab_alarm.
module gcab_gate (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  gcab_pkg::in_t     in_i,
  input  gcab_pkg::cfg_t    cfg_i,
  input  logic [2:0]        pend_i,
  output gcab_pkg::gate_out_t res_o
);
  import gcab_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT     = 8'b0000_0001,
    ST_CLOSED   = 8'b0000_0010,
    ST_OPENING  = 8'b0000_0100,
    ST_OPEN     = 8'b0000_1000,
    ST_CLOSING  = 8'b0001_0000,
    ST_OP_PAUSE = 8'b0010_0000,
    ST_CL_PAUSE = 8'b0100_0000,
    ST_RECOVERY = 8'b1000_0000
  } main_e;

  main_e      st_q, st_d;
  timer_t     travel_q, travel_d;
  timer_t     blink_q, blink_d;
  logic [7:0] lamp_q, lamp_d;
  lat_t       lat_q, lat_d;
  logic       prev_open_q, prev_close_q, prev_ph_q;
  logic [2:0] pend;
  logic       e1, e2, fo, fc, ph;
  timer_t     tl, t_dec, reload_arg, rl;
  logic [7:0] lhp;
  logic [2:0] st_num;

  assign fo  = in_i.fully_open;
  assign fc  = in_i.fully_closed;
  assign ph  = in_i.photocell;
  assign e1  = in_i.open_button & ~prev_open_q;
  assign e2  = in_i.close_button & ~prev_close_q;
  assign lhp = cfg_i.lamp_half_period;
  assign tl  = travel_load(cfg_i.travel_ticks);
  assign t_dec = (travel_q != '0) ? travel_q - timer_t'(1) : '0;

  // one shared divide-by-ten: the argument is what the blink reload sees
  always_comb begin
    if (st_q == ST_OPENING) begin
      reload_arg = t_dec;
    end else if (st_q == ST_CLOSING && !e1) begin
      reload_arg = travel_q;
    end else begin
      reload_arg = tl;
    end
  end
  assign rl = blink_reload(reload_arg);

  always_comb begin
    st_d     = st_q;
    travel_d = travel_q;
    blink_d  = blink_q;
    lamp_d   = lamp_q;
    lat_d    = lat_q;
    pend     = pend_i;
    unique case (st_q)
      ST_INIT: begin
        lat_d.l_closed = 1'b1; lat_d.l_open = 1'b1;
        lat_d.l_three  = 1'b1; lat_d.l_four = 1'b1;
        if (!fo && fc) begin
          st_d = ST_CLOSED;
        end else if (fo && !fc) begin
          st_d = ST_OPEN;
        end else begin
          st_d = ST_CLOSING;
        end
      end
      ST_CLOSED: begin
        lat_d.dir = 1'b1; lat_d.motor = 1'b0; lat_d.entry = 1'b0;
        lat_d.l_closed = 1'b1; lat_d.l_open = 1'b0; lat_d.l_three = 1'b0;
        lat_d.l_four = 1'b0; lat_d.l_motion = 1'b0;
        if (e1 && !ph) begin
          travel_d = tl; blink_d = rl; lamp_d = lhp;
          lat_d.motor = 1'b1;
          st_d = ST_OPENING;
        end else if (e2 && ph) begin
          pend = ALM_OBSTACLE;
        end else if (!fc) begin
          pend = ALM_INCOMPLETE;
        end
      end
      ST_OPENING: begin
        lat_d.dir = 1'b1; lat_d.motor = 1'b1; lat_d.entry = 1'b0;
        lat_d.l_closed = 1'b0; lat_d.l_four = 1'b0;
        if (fo) begin
          lat_d.motor = 1'b0; lat_d.lamp = 1'b0; lat_d.entry = 1'b1;
          st_d = ST_OPEN;
        end else if (e2 && !ph) begin
          travel_d = tl; blink_d = timer_t'(1);
          lat_d.dir = 1'b0; lat_d.motor = 1'b0;
          st_d = ST_OP_PAUSE;
        end else if (e1) begin
          st_d = ST_OP_PAUSE;
        end else if (e2 && ph) begin
          pend = ALM_OBSTACLE;
        end else begin
          travel_d = t_dec;
          if (travel_q == '0) begin
            pend = ALM_TIMEOUT;
          end
          if (blink_q != '0) begin
            blink_d = blink_q - timer_t'(1);
          end else begin
            lat_d.l_open = ~lat_q.l_open;
            blink_d = rl;
          end
          if (lamp_q != '0) begin
            lamp_d = lamp_q - 8'd1;
          end else begin
            lamp_d = lhp;
            lat_d.l_motion = ~lat_q.l_motion;
            lat_d.lamp = ~lat_q.lamp;
          end
        end
      end
      ST_OPEN: begin
        lat_d.dir = 1'b0; lat_d.motor = 1'b0; lat_d.entry = 1'b1;
        lat_d.l_closed = 1'b0; lat_d.l_open = 1'b1; lat_d.l_three = 1'b0;
        lat_d.l_four = 1'b0; lat_d.l_motion = 1'b0;
        // close request, or the barrier just cleared
        if ((e2 && !ph) || (!ph && prev_ph_q)) begin
          travel_d = tl; blink_d = rl; lamp_d = lhp;
          lat_d.motor = 1'b1; lat_d.entry = 1'b0;
          st_d = ST_CLOSING;
        end else begin
          if (e2 && ph) begin
            pend = ALM_OBSTACLE;
          end else if (!fo) begin
            pend = ALM_INCOMPLETE;
          end
          if (ph) begin
            lat_d.entry = 1'b0;
          end
        end
      end
      ST_CLOSING: begin
        lat_d.dir = 1'b0; lat_d.motor = 1'b1; lat_d.entry = 1'b0;
        lat_d.l_open = 1'b0; lat_d.l_three = 1'b0;
        if (fc) begin
          lat_d.motor = 1'b0; lat_d.lamp = 1'b0;
          st_d = ST_CLOSED;
        end else if (ph) begin
          pend = ALM_OBSTACLE;
          st_d = ST_CL_PAUSE;
        end else if (e1) begin
          travel_d = tl; blink_d = rl; lamp_d = LAMP_REVERSE_LOAD;
          lat_d.dir = 1'b1; lat_d.motor = 1'b0;
          st_d = ST_CL_PAUSE;
        end else if (e2) begin
          st_d = ST_CL_PAUSE;
        end else if (travel_q == '0) begin
          pend = ALM_TIMEOUT;
        end else if (blink_q == '0) begin
          lat_d.l_closed = ~lat_q.l_closed;
          blink_d = rl;
        end else if (lamp_q == '0) begin
          lamp_d = lhp;
          lat_d.l_motion = ~lat_q.l_motion;
          lat_d.lamp = ~lat_q.lamp;
        end
        // timers count down after the branch, whichever was taken
        if (lamp_d != '0) begin
          lamp_d = lamp_d - 8'd1;
        end
        if (travel_d != '0) begin
          travel_d = travel_d - timer_t'(1);
        end
        if (blink_d != '0) begin
          blink_d = blink_d - timer_t'(1);
        end
      end
      ST_OP_PAUSE: begin
        lat_d.dir = 1'b1; lat_d.motor = 1'b0; lat_d.entry = 1'b0; lat_d.lamp = 1'b0;
        if (e1) begin
          lat_d.motor = 1'b1; lamp_d = lhp;
          st_d = ST_OPENING;
        end else if (e2) begin
          travel_d = tl; blink_d = rl; lamp_d = lhp;
          lat_d.dir = 1'b0; lat_d.motor = 1'b1;
          st_d = ST_CLOSING;
        end
      end
      ST_CL_PAUSE: begin
        lat_d.dir = 1'b0; lat_d.motor = 1'b0; lat_d.entry = 1'b0; lat_d.lamp = 1'b0;
        if (e1) begin
          travel_d = tl; blink_d = rl; lamp_d = lhp;
          lat_d.dir = 1'b1; lat_d.motor = 1'b1;
          st_d = ST_OPENING;
        end else if (e2) begin
          lat_d.motor = 1'b1; lamp_d = lhp;
          st_d = ST_CLOSING;
        end
      end
      ST_RECOVERY: begin
        lat_d.dir = 1'b0; lat_d.motor = 1'b0; lat_d.entry = 1'b0; lat_d.lamp = 1'b0;
        lat_d.l_closed = ~lat_q.l_closed; lat_d.l_open = ~lat_q.l_open;
        lat_d.l_three  = ~lat_q.l_three;  lat_d.l_four = ~lat_q.l_four;
        // close wins when both edges arrive
        if (e2) begin
          travel_d = tl; blink_d = rl; lamp_d = lhp;
          lat_d.motor = 1'b1;
          st_d = ST_CLOSING;
        end else if (e1) begin
          travel_d = tl; blink_d = rl; lamp_d = lhp;
          lat_d.dir = 1'b1; lat_d.motor = 1'b1;
          st_d = ST_OPENING;
        end
      end
      default: begin
        st_d = ST_INIT;
      end
    endcase
    if (fo && fc) begin
      pend = ALM_SENSOR;
    end
  end

  always_comb begin
    unique case (st_d)
      ST_INIT:     st_num = GS_INIT;
      ST_CLOSED:   st_num = GS_CLOSED;
      ST_OPENING:  st_num = GS_OPENING;
      ST_OPEN:     st_num = GS_OPEN;
      ST_CLOSING:  st_num = GS_CLOSING;
      ST_OP_PAUSE: st_num = GS_OP_PAUSE;
      ST_CL_PAUSE: st_num = GS_CL_PAUSE;
      ST_RECOVERY: st_num = GS_RECOVERY;
      default:     st_num = GS_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_INIT;
      travel_q     <= '0;
      blink_q      <= '0;
      lamp_q       <= '0;
      lat_q        <= '0;
      prev_open_q  <= 1'b0;
      prev_close_q <= 1'b0;
      prev_ph_q    <= 1'b0;
    end else if (fire_i) begin
      st_q         <= st_d;
      travel_q     <= travel_d;
      blink_q      <= blink_d;
      lamp_q       <= lamp_d;
      lat_q        <= lat_d;
      prev_open_q  <= in_i.open_button;
      prev_close_q <= in_i.close_button;
      prev_ph_q    <= ph;
    end
  end

  assign res_o.lat        = lat_d;
  assign res_o.gate_state = st_num;
  assign res_o.pend       = pend;

endmodule

>>> rtl/gcab_alarm.sv
// Alarm blink sequencer: flashes the pending alarm code as pulses on the LED.
// Depends on gcab_pkg; owns the pending alarm register.
module gcab_alarm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  gcab_pkg::cfg_t       cfg_i,
  input  logic [2:0]           pend_i,
  output logic [2:0]           pend_q_o,
  output gcab_pkg::alarm_out_t res_o
);
  import gcab_pkg::*;

  typedef enum logic [2:0] {
    AL_IDLE  = 3'b001,
    AL_PULSE = 3'b010,
    AL_GAP   = 3'b100
  } al_e;

  al_e        seq_q, seq_d;
  logic [2:0] pend_q, pend_d;
  logic [7:0] tmr_q, tmr_d;
  logic [2:0] left_q, left_d;
  logic       led_q, led_d;

  always_comb begin
    seq_d  = seq_q;
    pend_d = pend_i;
    tmr_d  = tmr_q;
    left_d = left_q;
    led_d  = led_q;
    unique case (seq_q)
      AL_IDLE: begin
        led_d = 1'b0;
        if (pend_i != ALM_NONE) begin
          tmr_d  = cfg_i.alarm_pulse_ticks;
          left_d = pend_i - 3'd1;
          seq_d  = AL_PULSE;
        end
      end
      AL_PULSE: begin
        led_d = 1'b1;
        tmr_d = tmr_q - 8'd1;
        if (tmr_d == '0) begin
          tmr_d = (left_q != '0) ? cfg_i.alarm_short_gap : cfg_i.alarm_long_gap;
          seq_d = AL_GAP;
        end
      end
      AL_GAP: begin
        led_d = 1'b0;
        tmr_d = tmr_q - 8'd1;
        if (tmr_d == '0) begin
          if (left_q != '0) begin
            tmr_d  = cfg_i.alarm_pulse_ticks;
            left_d = left_q - 3'd1;
            seq_d  = AL_PULSE;
          end else begin
            // code fully shown, drop it
            pend_d = ALM_NONE;
            seq_d  = AL_IDLE;
          end
        end
      end
      default: begin
        seq_d = AL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= AL_IDLE;
      pend_q <= ALM_NONE;
      tmr_q  <= '0;
      left_q <= '0;
      led_q  <= 1'b0;
    end else if (fire_i) begin
      seq_q  <= seq_d;
      pend_q <= pend_d;
      tmr_q  <= tmr_d;
      left_q <= left_d;
      led_q  <= led_d;
    end
  end

  assign pend_q_o         = pend_q;
  assign res_o.led_alarm  = led_d;
  assign res_o.alarm_code = pend_d;

endmodule

>>> rtl/gate_controller_with_alarm_blink_core.sv
// Top level of the gate controller: input register, config registers,
// result register. Depends on gcab_pkg, gcab_gate and gcab_alarm.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one scan tick per
//   request: button, limit sensor and photocell levels. Output channel
//   (out_valid_o/out_ready_i/out_data_o) returns exactly one result per tick:
//   motor, direction, lamp, entry light, panel LEDs, gate state and alarm code.
//   Flow: an accepted request is captured in the input register and is
//   processed from there once the result register is free, which then
//   registers its result. Throughput: one request per clock unless the
//   receiver stalls; the state update between the registers is combinational.
//   When the receiver stalls, the result register holds; one more request
//   can sit in the input register, after which in_ready_o drops.
//   Config writes (cfg_we_i/cfg_index_i/cfg_data_i) take effect at once and
//   belong in idle periods. Unknown indexes are ignored.
//   Reset: gate machine in its initial test state, all latches, timers and
//   edge history cleared, config registers at their default values.
module gate_controller_with_alarm_blink_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  gcab_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output gcab_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [gcab_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gcab_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import gcab_pkg::*;

  logic       in_vld_q;
  in_t        in_data_q;
  logic       out_vld_q;
  out_t       out_data_q, out_d;
  cfg_t       cfg_q;
  logic       out_free, fire;
  logic [2:0] pend_q;
  gate_out_t  gate_res;
  alarm_out_t alarm_res;

  assign out_free   = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.travel_ticks      <= RST_TRAVEL_TICKS;
      cfg_q.lamp_half_period  <= RST_LAMP_HALF_PERIOD;
      cfg_q.alarm_pulse_ticks <= RST_ALARM_PULSE_TICKS;
      cfg_q.alarm_short_gap   <= RST_ALARM_SHORT_GAP;
      cfg_q.alarm_long_gap    <= RST_ALARM_LONG_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TRAVEL_TICKS:      cfg_q.travel_ticks      <= cfg_data_i;
        CFG_LAMP_HALF_PERIOD:  cfg_q.lamp_half_period  <= cfg_data_i[7:0];
        CFG_ALARM_PULSE_TICKS: cfg_q.alarm_pulse_ticks <= cfg_data_i[7:0];
        CFG_ALARM_SHORT_GAP:   cfg_q.alarm_short_gap   <= cfg_data_i[7:0];
        CFG_ALARM_LONG_GAP:    cfg_q.alarm_long_gap    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= out_d;
    end
  end

  gcab_gate u_gate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_data_q),
    .cfg_i  (cfg_q),
    .pend_i (pend_q),
    .res_o  (gate_res)
  );

  gcab_alarm u_alarm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .cfg_i    (cfg_q),
    .pend_i   (gate_res.pend),
    .pend_q_o (pend_q),
    .res_o    (alarm_res)
  );

  always_comb begin
    out_d.motor_on       = gate_res.lat.motor;
    out_d.direction_open = gate_res.lat.dir;
    out_d.warning_lamp   = gate_res.lat.lamp;
    out_d.entry_green    = gate_res.lat.entry;
    out_d.led_closed     = gate_res.lat.l_closed;
    out_d.led_open       = gate_res.lat.l_open;
    out_d.led_three      = gate_res.lat.l_three;
    out_d.led_four       = gate_res.lat.l_four;
    out_d.led_motion     = gate_res.lat.l_motion;
    out_d.led_alarm      = alarm_res.led_alarm;
    out_d.gate_state     = gate_res.gate_state;
    out_d.alarm_code     = alarm_res.alarm_code;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/gcab_checker.sv
// Port-level checker for the gate controller, bound to the top level.
// Depends on gcab_pkg and the assertion macro header.
`include "gate_controller_with_alarm_blink_core_assert.svh"

module gcab_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input gcab_pkg::out_t out_data_o
);
  import gcab_pkg::*;

  // stalled result holds
  `GCAB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // input side only backs up behind a stalled output
  `GCAB_ASSERT_NOW(a_ready_stall, !in_ready_o, out_valid_o && !out_ready_i)

  // motor is never running with the gate at rest in an end position
  `GCAB_ASSERT_NOW(a_motor_state, out_valid_o && out_data_o.motor_on, out_data_o.gate_state != GS_CLOSED && out_data_o.gate_state != GS_OPEN)

  // entry is never green with the motor running
  `GCAB_ASSERT_NOW(a_entry_motor, out_valid_o && out_data_o.motor_on, !out_data_o.entry_green)

  // alarm LED lights only while a code is pending
  `GCAB_ASSERT_NOW(a_led_code, out_valid_o && out_data_o.led_alarm, out_data_o.alarm_code != ALM_NONE)

endmodule

bind gate_controller_with_alarm_blink_core gcab_checker u_gcab_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for gate_controller_with_alarm_blink_core.
// Drives scan ticks over valid/ready, predicts every result in SV and compares it.
// Depends on gcab_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gcab_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  // alarm sequencer states
  localparam logic [1:0] SEQ_IDLE  = 2'd0;
  localparam logic [1:0] SEQ_PULSE = 2'd1;
  localparam logic [1:0] SEQ_GAP   = 2'd2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gate_controller_with_alarm_blink_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted block state
  cfg_t       cfg_sh;
  logic [2:0] gs_q, pend_q, pulses_q;
  logic [1:0] seq_q;
  timer_t     travel_q, blink_q;
  logic [7:0] lamp_q, atmr_q;
  logic       prev_open_q, prev_close_q, prev_photo_q;
  lat_t       lat_q;
  logic       alarm_led_q;

  out_t predicted_levels_q [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stuck_cycles = 0;

  // simple gate plant used to shape the random stimulus
  int gate_pos = 0;
  int gate_span = 8;
  logic open_lvl = 1'b0, close_lvl = 1'b0, photo_lvl = 1'b0;

  function automatic timer_t blink_of(timer_t t);
    return timer_t'(t / 10 + 1);
  endfunction

  function automatic void begin_travel();
    travel_q = cfg_sh.travel_ticks;
    blink_q  = blink_of(travel_q);
    lamp_q   = cfg_sh.lamp_half_period;
  endfunction

  // one scan tick of the gate machine and the alarm sequencer
  function automatic out_t advance_gate(in_t t);
    logic e_open, e_close;
    out_t r;
    e_open  = t.open_button && !prev_open_q;
    e_close = t.close_button && !prev_close_q;
    case (gs_q)
      GS_INIT: begin
        lat_q.l_closed = 1'b1; lat_q.l_open = 1'b1;
        lat_q.l_three = 1'b1; lat_q.l_four = 1'b1;
        if (!t.fully_open && t.fully_closed) gs_q = GS_CLOSED;
        else if (t.fully_open && !t.fully_closed) gs_q = GS_OPEN;
        else gs_q = GS_CLOSING;
      end
      GS_CLOSED: begin
        lat_q.dir = 1'b1; lat_q.motor = 1'b0; lat_q.entry = 1'b0;
        lat_q.l_closed = 1'b1; lat_q.l_open = 1'b0; lat_q.l_three = 1'b0;
        lat_q.l_four = 1'b0; lat_q.l_motion = 1'b0;
        if (e_open && !t.photocell) begin
          begin_travel();
          lat_q.motor = 1'b1;
          gs_q = GS_OPENING;
        end else if (e_close && t.photocell) begin
          pend_q = ALM_OBSTACLE;
        end else if (!t.fully_closed) begin
          pend_q = ALM_INCOMPLETE;
        end
      end
      GS_OPENING: begin
        lat_q.dir = 1'b1; lat_q.motor = 1'b1; lat_q.entry = 1'b0;
        lat_q.l_closed = 1'b0; lat_q.l_four = 1'b0;
        if (t.fully_open) begin
          lat_q.motor = 1'b0; lat_q.lamp = 1'b0; lat_q.entry = 1'b1;
          gs_q = GS_OPEN;
        end else if (e_close && !t.photocell) begin
          travel_q = cfg_sh.travel_ticks;
          blink_q = timer_t'(1);
          lat_q.dir = 1'b0; lat_q.motor = 1'b0;
          gs_q = GS_OP_PAUSE;
        end else if (e_open) begin
          gs_q = GS_OP_PAUSE;
        end else if (e_close && t.photocell) begin
          pend_q = ALM_OBSTACLE;
        end else begin
          if (travel_q != 0) travel_q--;
          else pend_q = ALM_TIMEOUT;
          if (blink_q != 0) begin
            blink_q--;
          end else begin
            lat_q.l_open = ~lat_q.l_open;
            blink_q = blink_of(travel_q);
          end
          if (lamp_q != 0) begin
            lamp_q--;
          end else begin
            lamp_q = cfg_sh.lamp_half_period;
            lat_q.l_motion = ~lat_q.l_motion;
            lat_q.lamp = ~lat_q.lamp;
          end
        end
      end
      GS_OPEN: begin
        lat_q.dir = 1'b0; lat_q.motor = 1'b0; lat_q.entry = 1'b1;
        lat_q.l_closed = 1'b0; lat_q.l_open = 1'b1; lat_q.l_three = 1'b0;
        lat_q.l_four = 1'b0; lat_q.l_motion = 1'b0;
        // close request, or the light barrier just cleared
        if ((e_close && !t.photocell) || (!t.photocell && prev_photo_q)) begin
          begin_travel();
          lat_q.motor = 1'b1; lat_q.entry = 1'b0;
          gs_q = GS_CLOSING;
        end else begin
          if (e_close && t.photocell) pend_q = ALM_OBSTACLE;
          else if (!t.fully_open) pend_q = ALM_INCOMPLETE;
          if (t.photocell) lat_q.entry = 1'b0;
        end
      end
      GS_CLOSING: begin
        lat_q.dir = 1'b0; lat_q.motor = 1'b1; lat_q.entry = 1'b0;
        lat_q.l_open = 1'b0; lat_q.l_three = 1'b0;
        if (t.fully_closed) begin
          lat_q.motor = 1'b0; lat_q.lamp = 1'b0;
          gs_q = GS_CLOSED;
        end else if (t.photocell) begin
          pend_q = ALM_OBSTACLE;
          gs_q = GS_CL_PAUSE;
        end else if (e_open) begin
          travel_q = cfg_sh.travel_ticks;
          blink_q = blink_of(travel_q);
          lamp_q = LAMP_REVERSE_LOAD;
          lat_q.dir = 1'b1; lat_q.motor = 1'b0;
          gs_q = GS_CL_PAUSE;
        end else if (e_close) begin
          gs_q = GS_CL_PAUSE;
        end else if (travel_q == 0) begin
          pend_q = ALM_TIMEOUT;
        end else if (blink_q == 0) begin
          lat_q.l_closed = ~lat_q.l_closed;
          blink_q = blink_of(travel_q);
        end else if (lamp_q == 0) begin
          lamp_q = cfg_sh.lamp_half_period;
          lat_q.l_motion = ~lat_q.l_motion;
          lat_q.lamp = ~lat_q.lamp;
        end
        // timers count down on every closing tick, whatever happened above
        if (lamp_q != 0) lamp_q--;
        if (travel_q != 0) travel_q--;
        if (blink_q != 0) blink_q--;
      end
      GS_OP_PAUSE: begin
        lat_q.dir = 1'b1; lat_q.motor = 1'b0; lat_q.entry = 1'b0; lat_q.lamp = 1'b0;
        if (e_open) begin
          lat_q.motor = 1'b1;
          lamp_q = cfg_sh.lamp_half_period;
          gs_q = GS_OPENING;
        end else if (e_close) begin
          begin_travel();
          lat_q.dir = 1'b0; lat_q.motor = 1'b1;
          gs_q = GS_CLOSING;
        end
      end
      GS_CL_PAUSE: begin
        lat_q.dir = 1'b0; lat_q.motor = 1'b0; lat_q.entry = 1'b0; lat_q.lamp = 1'b0;
        if (e_open) begin
          begin_travel();
          lat_q.dir = 1'b1; lat_q.motor = 1'b1;
          gs_q = GS_OPENING;
        end else if (e_close) begin
          lat_q.motor = 1'b1;
          lamp_q = cfg_sh.lamp_half_period;
          gs_q = GS_CLOSING;
        end
      end
      default: begin
        lat_q.dir = 1'b0; lat_q.motor = 1'b0; lat_q.entry = 1'b0; lat_q.lamp = 1'b0;
        lat_q.l_closed = ~lat_q.l_closed; lat_q.l_open = ~lat_q.l_open;
        lat_q.l_three = ~lat_q.l_three; lat_q.l_four = ~lat_q.l_four;
        if (e_open) begin
          begin_travel();
          lat_q.dir = 1'b1; lat_q.motor = 1'b1;
          gs_q = GS_OPENING;
        end
        // close wins when both edges arrive
        if (e_close) begin
          begin_travel();
          lat_q.dir = 1'b0; lat_q.motor = 1'b1;
          gs_q = GS_CLOSING;
        end
      end
    endcase

    if (t.fully_open && t.fully_closed) pend_q = ALM_SENSOR;

    case (seq_q)
      SEQ_IDLE: begin
        alarm_led_q = 1'b0;
        if (pend_q != ALM_NONE) begin
          atmr_q = cfg_sh.alarm_pulse_ticks;
          pulses_q = pend_q - 3'd1;
          seq_q = SEQ_PULSE;
        end
      end
      SEQ_PULSE: begin
        alarm_led_q = 1'b1;
        atmr_q = atmr_q - 8'd1;
        if (atmr_q == 0) begin
          atmr_q = (pulses_q != 0) ? cfg_sh.alarm_short_gap : cfg_sh.alarm_long_gap;
          seq_q = SEQ_GAP;
        end
      end
      SEQ_GAP: begin
        alarm_led_q = 1'b0;
        atmr_q = atmr_q - 8'd1;
        if (atmr_q == 0) begin
          if (pulses_q != 0) begin
            atmr_q = cfg_sh.alarm_pulse_ticks;
            pulses_q = pulses_q - 3'd1;
            seq_q = SEQ_PULSE;
          end else begin
            pend_q = ALM_NONE;
            seq_q = SEQ_IDLE;
          end
        end
      end
      default: ;
    endcase

    prev_open_q = t.open_button;
    prev_close_q = t.close_button;
    prev_photo_q = t.photocell;

    r.motor_on       = lat_q.motor;
    r.direction_open = lat_q.dir;
    r.warning_lamp   = lat_q.lamp;
    r.entry_green    = lat_q.entry;
    r.led_closed     = lat_q.l_closed;
    r.led_open       = lat_q.l_open;
    r.led_three      = lat_q.l_three;
    r.led_four       = lat_q.l_four;
    r.led_motion     = lat_q.l_motion;
    r.led_alarm      = alarm_led_q;
    r.gate_state     = gs_q;
    r.alarm_code     = pend_q;
    return r;
  endfunction

  // next scan tick from the plant: sensors follow the predicted motion,
  // buttons and photocell toggle at random, with occasional glitches and noise
  function automatic in_t next_scan();
    in_t t;
    if (gs_q == GS_OPENING && gate_pos < gate_span) gate_pos++;
    else if (gs_q == GS_CLOSING && gate_pos > 0) gate_pos--;
    if ($urandom_range(99) < 5) open_lvl = ~open_lvl;
    if ($urandom_range(99) < 5) close_lvl = ~close_lvl;
    if (photo_lvl) begin
      if ($urandom_range(99) < 35) photo_lvl = 1'b0;
    end else if ($urandom_range(99) < 4) begin
      photo_lvl = 1'b1;
    end
    t.open_button  = open_lvl;
    t.close_button = close_lvl;
    t.photocell    = photo_lvl;
    t.fully_open   = (gate_pos >= gate_span);
    t.fully_closed = (gate_pos == 0);
    if ($urandom_range(99) < 5) begin
      t.fully_open = 1'($urandom_range(1));
      t.fully_closed = 1'($urandom_range(1));
    end
    if ($urandom_range(99) < 3) t = in_t'(5'($urandom_range(31)));
    return t;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [2:0] got,
                             input logic [2:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_bit(input string name, input logic got, input logic want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    out_t exp_lv;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_levels_q.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        exp_lv = predicted_levels_q.pop_front();
        check_bit("motor_on", out_data_o.motor_on, exp_lv.motor_on);
        check_bit("direction_open", out_data_o.direction_open, exp_lv.direction_open);
        check_bit("warning_lamp", out_data_o.warning_lamp, exp_lv.warning_lamp);
        check_bit("entry_green", out_data_o.entry_green, exp_lv.entry_green);
        check_bit("led_closed", out_data_o.led_closed, exp_lv.led_closed);
        check_bit("led_open", out_data_o.led_open, exp_lv.led_open);
        check_bit("led_three", out_data_o.led_three, exp_lv.led_three);
        check_bit("led_four", out_data_o.led_four, exp_lv.led_four);
        check_bit("led_motion", out_data_o.led_motion, exp_lv.led_motion);
        check_bit("led_alarm", out_data_o.led_alarm, exp_lv.led_alarm);
        check_field("gate_state", out_data_o.gate_state, exp_lv.gate_state);
        check_field("alarm_code", out_data_o.alarm_code, exp_lv.alarm_code);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_idle_pct);
  end

  // ends the run when no handshake happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress on either channel", $realtime);
        $display("** gate_controller_with_alarm_blink_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_tick(input in_t t);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = t;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_levels_q.push_back(advance_gate(t));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (predicted_levels_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_TRAVEL_TICKS:      cfg_sh.travel_ticks = val;
      CFG_LAMP_HALF_PERIOD:  cfg_sh.lamp_half_period = val[7:0];
      CFG_ALARM_PULSE_TICKS: cfg_sh.alarm_pulse_ticks = val[7:0];
      CFG_ALARM_SHORT_GAP:   cfg_sh.alarm_short_gap = val[7:0];
      CFG_ALARM_LONG_GAP:    cfg_sh.alarm_long_gap = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int travel, input int lamp, input int pulse,
                            input int sgap, input int lgap);
    drain();
    repeat (3) @(negedge clk_i);
    write_reg(CFG_TRAVEL_TICKS, CFG_DATA_W'(travel));
    write_reg(CFG_LAMP_HALF_PERIOD, CFG_DATA_W'(lamp));
    write_reg(CFG_ALARM_PULSE_TICKS, CFG_DATA_W'(pulse));
    write_reg(CFG_ALARM_SHORT_GAP, CFG_DATA_W'(sgap));
    write_reg(CFG_ALARM_LONG_GAP, CFG_DATA_W'(lgap));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    gate_span = $urandom_range(24, 1);
  endtask

  task automatic run_scans(input int n);
    repeat (n) send_tick(next_scan());
  endtask

  task automatic test_directed();
    logic [4:0] script [25] = '{
      // {open, close, fully_open, fully_closed, photocell}
      5'b00110, 5'b00000, 5'b00010, 5'b01011, 5'b00010,
      5'b10011, 5'b00010, 5'b10010, 5'b00000, 5'b10000,
      5'b01000, 5'b00001, 5'b10000, 5'b01000, 5'b10000,
      5'b01001, 5'b00100, 5'b00101, 5'b00100, 5'b10000,
      5'b01000, 5'b00000, 5'b01000, 5'b11000, 5'b00000};
    // both sensors from the initial state, then the initial close that
    // times out at once, obstacle, pause and reversal paths
    foreach (script[i]) send_tick(in_t'(script[i]));
    drain();
  endtask

  task automatic test_register_extremes();
    set_config(1, 1, 1, 1, 1);
    run_scans(200);
    set_config(1023, 255, 255, 255, 255);
    run_scans(200);
    // unused index must leave every register alone
    drain();
    repeat (3) @(negedge clk_i);
    write_reg(CFG_IDX_UNUSED, '1);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    run_scans(20);
    // zero alarm timing wraps the alarm timer
    set_config(5, 2, 0, 0, 0);
    run_scans(130);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      set_config($urandom_range(60, 1), $urandom_range(12, 1), $urandom_range(6, 1),
                 $urandom_range(8, 1), $urandom_range(30, 1));
      run_scans(150);
    end
    set_config($urandom_range(1023, 1), $urandom_range(255, 1), $urandom_range(255, 1),
               $urandom_range(255, 1), $urandom_range(255, 1));
    run_scans(150);
  endtask

  task automatic test_drain_midstream();
    set_config(RST_TRAVEL_TICKS, RST_LAMP_HALF_PERIOD, RST_ALARM_PULSE_TICKS,
               RST_ALARM_SHORT_GAP, RST_ALARM_LONG_GAP);
    run_scans(150);
    drain();
    run_scans(150);
  endtask

  initial begin
    cfg_sh = '{RST_TRAVEL_TICKS, RST_LAMP_HALF_PERIOD, RST_ALARM_PULSE_TICKS,
               RST_ALARM_SHORT_GAP, RST_ALARM_LONG_GAP};
    gs_q = GS_INIT; pend_q = ALM_NONE; seq_q = SEQ_IDLE; pulses_q = '0;
    travel_q = '0; blink_q = '0; lamp_q = '0; atmr_q = '0;
    prev_open_q = 1'b0; prev_close_q = 1'b0; prev_photo_q = 1'b0;
    lat_q = '0; alarm_led_q = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 6; recv_idle_pct = 52;
    test_directed();
    test_register_extremes();
    send_idle_pct = 52; recv_idle_pct = 6;
    test_random_settings();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_drain_midstream();

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** gate_controller_with_alarm_blink_core: PASSED **");
    end else begin
      $display("** gate_controller_with_alarm_blink_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/gcab_pkg.sv
rtl/gcab_gate.sv
rtl/gcab_alarm.sv
rtl/gate_controller_with_alarm_blink_core.sv
rtl/gcab_checker.sv
tb/tb_top.sv
